@@ hw/rtl/gsc_pkg.sv @@
package gsc_pkg;

  // Outstanding results the output queue can hold.
  localparam int OUT_DEPTH = 8;

  // Byte address width of the register port.
  localparam int CFG_AW = 4;

  typedef logic signed [15:0] gyro_t;
  typedef logic [1:0] axis_t;

  localparam axis_t AXIS_NONE = 2'd0;
  localparam axis_t AXIS_X    = 2'd1;
  localparam axis_t AXIS_Y    = 2'd2;
  localparam axis_t AXIS_Z    = 2'd3;

  // Register indexes, taken from paddr[3:2].
  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_MIN_VAR  = 2'd0;
  localparam reg_idx_t REG_MAX_VAR  = 2'd1;
  localparam reg_idx_t REG_ACT_WIN  = 2'd2;
  localparam reg_idx_t REG_STEP_WIN = 2'd3;

  typedef struct packed {
    logic [15:0] min_var;
    logic [15:0] max_var;
    logic [7:0]  act_win;
    logic [7:0]  step_win;
  } cfg_t;

  // Per-lane pipeline control.
  typedef struct packed {
    logic acc;   // sample accepted this cycle
    logic last;  // the accepted sample closes a tick
    logic upd;   // divided average is ready for the lane state
  } lane_ctl_t;

  // What one axis lane hands to the merging stage after a tick.
  typedef struct packed {
    gyro_t       prev;
    gyro_t       avg;
    gyro_t       peak_hi;
    gyro_t       peak_lo;
    logic [15:0] change;
  } lane_res_t;

  typedef struct packed {
    logic [31:0] step_total;
    axis_t       active_axis;
    logic        crossing_seen;
  } result_t;

  // Axis holding a strict unique maximum of three values, else none.
  function automatic axis_t unique_max3(input logic [15:0] a, input logic [15:0] b,
                                        input logic [15:0] c);
    axis_t sel;
    sel = AXIS_NONE;
    if (a > b && a > c) begin
      sel = AXIS_X;
    end else if (b > a && b > c) begin
      sel = AXIS_Y;
    end else if (c > a && c > b) begin
      sel = AXIS_Z;
    end
    return sel;
  endfunction

endpackage

@@ hw/rtl/gsc_if.sv @@
// Request channel carrying one three-axis gyro sample.
interface gsc_in_if;
  import gsc_pkg::*;

  logic  valid;
  logic  ready;
  gyro_t gyro_x;
  gyro_t gyro_y;
  gyro_t gyro_z;

  modport source (output valid, output gyro_x, output gyro_y, output gyro_z, input ready);
  modport sink   (input valid, input gyro_x, input gyro_y, input gyro_z, output ready);
endinterface

// Request channel carrying one per-tick result.
interface gsc_out_if;
  import gsc_pkg::*;

  logic        valid;
  logic        ready;
  logic [31:0] step_total;
  axis_t       active_axis;
  logic        crossing_seen;

  modport source (output valid, output step_total, output active_axis,
                  output crossing_seen, input ready);
  modport sink   (input valid, input step_total, input active_axis,
                  input crossing_seen, output ready);
endinterface

@@ hw/rtl/gyro_step_counter.sv @@
// Gyro step counter. Takes one three-axis sample per clock cycle unless a
// tick-closing sample is held back; every SAMPLES_PER_TICK samples form a tick,
// and each tick's result passes the tick-sum, product and lane-state registers
// and the output queue before it is offered on the output channel.
// The rate is set by the three axis lanes, which divide, filter and track the
// peaks in a short pipeline, and by the merging stage, which handles one tick
// per cycle. Up to eight results may be outstanding; only a tick-closing
// sample is held back when that many are waiting to be taken. Registers
// (APB, byte addresses 0, 4, 8, 12): minimum variation, maximum variation,
// activity window in ticks, step window in ticks; write them only while idle.
module gyro_step_counter #(
  parameter int SAMPLES_PER_TICK = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  gsc_in_if.sink                     in_ch,
  gsc_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gsc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import gsc_pkg::*;

  localparam int PH_W  = (SAMPLES_PER_TICK > 1) ? $clog2(SAMPLES_PER_TICK) : 1;
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  cfg_t             cfg_r;
  reg_idx_t         reg_idx;
  logic [PH_W-1:0]  phase_r;
  logic             last;
  logic             acc;
  logic             tick_acc;
  logic             pop;
  logic [CNT_W-1:0] pending_r;
  logic             vld_a_r;
  logic             vld_b_r;
  logic             vld_c_r;
  lane_ctl_t        lctl;
  gyro_t            smp [3];
  lane_res_t        lres [3];
  logic             res_vld;
  result_t          res;
  logic             head_vld;
  result_t          head;

  // Register port.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{min_var: 16'd2, max_var: 16'd1000, act_win: 8'd30, step_win: 8'd6};
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_MIN_VAR:  cfg_r.min_var  <= pwdata[15:0];
        REG_MAX_VAR:  cfg_r.max_var  <= pwdata[15:0];
        REG_ACT_WIN:  cfg_r.act_win  <= pwdata[7:0];
        REG_STEP_WIN: cfg_r.step_win <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MIN_VAR:  prdata = {16'd0, cfg_r.min_var};
      REG_MAX_VAR:  prdata = {16'd0, cfg_r.max_var};
      REG_ACT_WIN:  prdata = {24'd0, cfg_r.act_win};
      REG_STEP_WIN: prdata = {24'd0, cfg_r.step_win};
      default:      prdata = '0;
    endcase
  end

  // Sample phase within the tick and the credit for outstanding results.
  assign last         = phase_r == PH_W'(SAMPLES_PER_TICK - 1);
  assign in_ch.ready  = !last || (pending_r < CNT_W'(OUT_DEPTH));
  assign acc          = in_ch.valid && in_ch.ready;
  assign tick_acc     = acc && last;
  assign pop          = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      pending_r <= '0;
      vld_a_r   <= 1'b0;
      vld_b_r   <= 1'b0;
      vld_c_r   <= 1'b0;
    end else begin
      if (acc) begin
        phase_r <= last ? '0 : phase_r + 1'b1;
      end
      pending_r <= pending_r + CNT_W'(tick_acc) - CNT_W'(pop);
      vld_a_r   <= tick_acc;
      vld_b_r   <= vld_a_r;
      vld_c_r   <= vld_b_r;
    end
  end

  // One lane per axis.
  assign lctl   = '{acc: acc, last: last, upd: vld_b_r};
  assign smp[0] = in_ch.gyro_x;
  assign smp[1] = in_ch.gyro_y;
  assign smp[2] = in_ch.gyro_z;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    gsc_lane #(.SPT(SAMPLES_PER_TICK)) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (lctl),
      .sample (smp[g]),
      .cfg    (cfg_r),
      .res    (lres[g])
    );
  end

  gsc_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld     (vld_c_r),
    .cfg     (cfg_r),
    .lanes   (lres),
    .res_vld (res_vld),
    .res     (res)
  );

  gsc_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (res_vld),
    .wr_data  (res),
    .rd_en    (out_ch.ready),
    .rd_valid (head_vld),
    .rd_data  (head)
  );

  assign out_ch.valid         = head_vld;
  assign out_ch.step_total    = head.step_total;
  assign out_ch.active_axis   = head.active_axis;
  assign out_ch.crossing_seen = head.crossing_seen;

endmodule

@@ hw/rtl/gsc_lane.sv @@
module gsc_lane #(
  parameter int SPT = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gsc_pkg::lane_ctl_t ctl,
  input  gsc_pkg::gyro_t     sample,
  input  gsc_pkg::cfg_t      cfg,
  output gsc_pkg::lane_res_t res
);
  import gsc_pkg::*;

  // Sum of one tick, and an exact reciprocal for the truncating divide.
  localparam int SUM_W  = 16 + $clog2(SPT);
  localparam int SH     = SUM_W + $clog2(SPT);
  localparam longint unsigned RECIP_L = ((64'd1 << SH) + 64'(SPT) - 64'd1) / 64'(SPT);
  localparam logic [SH:0] RECIP = (SH + 1)'(RECIP_L);
  localparam int PROD_W = SUM_W + SH + 1;

  logic signed [SUM_W-1:0] acc_r;
  logic signed [SUM_W-1:0] acc_sum;
  logic signed [SUM_W-1:0] tick_sum_r;
  logic [SUM_W-1:0]        mag;
  logic [PROD_W-1:0]       prod_r;
  logic                    neg_r;
  logic [16:0]             quo;
  logic signed [16:0]      avg17;
  gyro_t                   new_avg;
  logic signed [16:0]      diff;
  logic [15:0]             chg;
  logic                    keep;
  gyro_t                   kept;
  gyro_t                   prev_r;
  gyro_t                   avg_r;
  gyro_t                   hi_r;
  gyro_t                   lo_r;
  logic [15:0]             chg_r;

  // Accumulate samples of the running tick; restart on the closing sample.
  assign acc_sum = acc_r + SUM_W'(sample);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.acc) begin
      acc_r <= ctl.last ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.acc && ctl.last) begin
      tick_sum_r <= acc_sum;
    end
  end

  // Divide the magnitude by a reciprocal multiply; the sign is restored later.
  assign mag = tick_sum_r[SUM_W-1] ? SUM_W'(-tick_sum_r) : tick_sum_r;

  always_ff @(posedge clk) begin
    prod_r <= {{(SH + 1){1'b0}}, mag} * {{SUM_W{1'b0}}, RECIP};
    neg_r  <= tick_sum_r[SUM_W-1];
  end

  // Signed average, its change and the variation window check.
  always_comb begin
    quo     = prod_r[SH +: 17];
    avg17   = neg_r ? -$signed(quo) : $signed(quo);
    new_avg = avg17[15:0];
    diff    = {new_avg[15], new_avg} - {avg_r[15], avg_r};
    chg     = diff[16] ? 16'(-diff) : diff[15:0];
    keep    = !(chg < cfg.min_var || chg > cfg.max_var);
    kept    = keep ? new_avg : avg_r;
  end

  // Lane state: averages and running peaks, advanced once per tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      avg_r  <= '0;
      hi_r   <= '0;
      lo_r   <= '0;
      chg_r  <= '0;
    end else if (ctl.upd) begin
      prev_r <= avg_r;
      avg_r  <= kept;
      hi_r   <= (kept > hi_r) ? kept : hi_r;
      lo_r   <= (kept < lo_r) ? kept : lo_r;
      chg_r  <= keep ? chg : '0;
    end
  end

  assign res = '{prev: prev_r, avg: avg_r, peak_hi: hi_r, peak_lo: lo_r, change: chg_r};

endmodule

@@ hw/rtl/gsc_merge.sv @@
module gsc_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld,
  input  gsc_pkg::cfg_t      cfg,
  input  gsc_pkg::lane_res_t lanes [3],
  output logic               res_vld,
  output gsc_pkg::result_t   res
);
  import gsc_pkg::*;

  logic [7:0]         wgt_r [3];
  logic [7:0]         act_cnt_r;
  axis_t              chosen_r;
  logic [15:0]        cross_cnt_r;
  logic [7:0]         step_cnt_r;
  logic [31:0]        steps_r;

  logic [7:0]         wgt_nxt [3];
  logic [7:0]         wgt_base [3];
  logic [7:0]         act_cnt_nxt;
  logic [7:0]         act_inc;
  logic               act_end;
  axis_t              chosen_nxt;
  axis_t              busy;
  logic signed [16:0] msum [3];
  logic signed [16:0] mid17 [3];
  gyro_t              mid [3];
  logic               cross_l [3];
  logic               crossed;
  logic [15:0]        cross_inc;
  logic [15:0]        cross_cnt_nxt;
  logic [7:0]         step_inc;
  logic               step_end;
  logic [7:0]         step_cnt_nxt;
  logic [31:0]        steps_nxt;

  always_comb begin
    // Activity window: pick the most active axis before this tick's weight.
    act_inc    = act_cnt_r + 8'd1;
    act_end    = act_inc >= cfg.act_win;
    act_cnt_nxt = act_end ? '0 : act_inc;
    chosen_nxt = act_end ? unique_max3({8'd0, wgt_r[0]}, {8'd0, wgt_r[1]}, {8'd0, wgt_r[2]})
                         : chosen_r;

    // The axis with the unique largest change gains one saturating weight.
    busy = unique_max3(lanes[0].change, lanes[1].change, lanes[2].change);
    for (int i = 0; i < 3; i++) begin
      wgt_base[i] = act_end ? '0 : wgt_r[i];
      wgt_nxt[i]  = (busy == axis_t'(i + 1) && wgt_base[i] != 8'hFF) ?
                    wgt_base[i] + 8'd1 : wgt_base[i];
    end

    // Midpoint of the peaks, truncated toward zero, and strict crossings.
    for (int i = 0; i < 3; i++) begin
      msum[i]    = {lanes[i].peak_hi[15], lanes[i].peak_hi} +
                   {lanes[i].peak_lo[15], lanes[i].peak_lo};
      mid17[i]   = $signed(msum[i] + {16'd0, msum[i][16]}) >>> 1;
      mid[i]     = mid17[i][15:0];
      cross_l[i] = (lanes[i].prev < mid[i] && lanes[i].avg > mid[i]) ||
                   (lanes[i].prev > mid[i] && lanes[i].avg < mid[i]);
    end

    case (chosen_nxt)
      AXIS_X:  crossed = cross_l[0];
      AXIS_Y:  crossed = cross_l[1];
      AXIS_Z:  crossed = cross_l[2];
      default: crossed = 1'b0;
    endcase

    cross_inc = (crossed && cross_cnt_r != 16'hFFFF) ? cross_cnt_r + 16'd1 : cross_cnt_r;

    // Step window: any crossing inside it is worth one step.
    step_inc     = step_cnt_r + 8'd1;
    step_end     = step_inc >= cfg.step_win;
    step_cnt_nxt = step_end ? '0 : step_inc;
    if (step_end && cross_inc != '0) begin
      cross_cnt_nxt = '0;
      steps_nxt     = steps_r + 32'd1;
    end else begin
      cross_cnt_nxt = cross_inc;
      steps_nxt     = steps_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        wgt_r[i] <= '0;
      end
      act_cnt_r   <= '0;
      chosen_r    <= AXIS_NONE;
      cross_cnt_r <= '0;
      step_cnt_r  <= '0;
      steps_r     <= '0;
    end else if (vld) begin
      for (int i = 0; i < 3; i++) begin
        wgt_r[i] <= wgt_nxt[i];
      end
      act_cnt_r   <= act_cnt_nxt;
      chosen_r    <= chosen_nxt;
      cross_cnt_r <= cross_cnt_nxt;
      step_cnt_r  <= step_cnt_nxt;
      steps_r     <= steps_nxt;
    end
  end

  assign res_vld = vld;
  assign res     = '{step_total: steps_nxt, active_axis: chosen_nxt, crossing_seen: crossed};

endmodule

@@ hw/rtl/gsc_out_fifo.sv @@
module gsc_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  gsc_pkg::result_t wr_data,
  input  logic             rd_en,
  output logic             rd_valid,
  output gsc_pkg::result_t rd_data
);
  import gsc_pkg::*;

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  result_t          mem_r [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pop;

  assign pop = rd_en && rd_valid;

  // Result storage; the writer never overruns it thanks to the credit count.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(wr_en) - CNT_W'(pop);
    end
  end

  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rd_ptr_r];

endmodule

@@ hw/rtl/gsc_checker.sv @@
module gsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] step_total,
  input logic [1:0]  active_axis,
  input logic        crossing_seen
);
  import gsc_pkg::*;

  logic [31:0] last_step_r;

  // Step total of the last result taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_step_r <= '0;
    end else if (out_valid && out_ready) begin
      last_step_r <= step_total;
    end
  end

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A crossing can only be seen on a chosen axis.
  a_cross_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && crossing_seen) |-> (active_axis != AXIS_NONE))
    else $error("crossing reported with no active axis");

  // A result held back keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(step_total)))
    else $error("stalled result changed");

  // Consecutive results differ by at most one step.
  a_step_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |->
      (step_total == last_step_r || step_total == last_step_r + 32'd1))
    else $error("step total jumped");

endmodule

bind gyro_step_counter gsc_checker u_gsc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .step_total    (out_ch.step_total),
  .active_axis   (out_ch.active_axis),
  .crossing_seen (out_ch.crossing_seen)
);

@@ tb/sv/gsc_tick_checker.sv @@
`timescale 1ns / 1ps

// Watches the sample and tick-result channels and the register port. It keeps
// its own copy of the step counter's state, predicts a result for every request
// that closes a tick, and compares each result request with the oldest
// prediction.
module gsc_tick_checker
  import gsc_pkg::*;
#(
  parameter int TICK_LEN = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  gsc_in_if                 in_mon,
  gsc_out_if                out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int                fail_count,
  output int                due_count,
  output int                samples_seen,
  output int                results_seen,
  output int                crossing_total
);

  // Register copy and predicted block state.
  cfg_t        cfg;
  logic [7:0]  phase_cnt;
  int          sum_acc [3];
  gyro_t       avg_now [3];
  gyro_t       avg_prev [3];
  gyro_t       peak_hi [3];
  gyro_t       peak_lo [3];
  logic [7:0]  weight [3];
  logic [7:0]  act_ticks;
  axis_t       chosen;
  logic [15:0] cross_cnt;
  logic [7:0]  step_ticks;
  logic [31:0] steps;

  // Predicted tick results, oldest first.
  result_t ticks_due [$];

  // Axis with a value above both others, or none when the top value is shared.
  function automatic axis_t pick_leader(input int unsigned a, input int unsigned b,
                                        input int unsigned c);
    int unsigned top;
    int          hits;
    axis_t       lead;
    top = a;
    if (b > top) top = b;
    if (c > top) top = c;
    hits = 0;
    lead = AXIS_NONE;
    if (a == top) begin
      hits++;
      lead = AXIS_X;
    end
    if (b == top) begin
      hits++;
      lead = AXIS_Y;
    end
    if (c == top) begin
      hits++;
      lead = AXIS_Z;
    end
    return (hits == 1) ? lead : AXIS_NONE;
  endfunction

  // Return the predicted state to its value after reset.
  task automatic clear_state();
    cfg = '{min_var: 16'd2, max_var: 16'd1000, act_win: 8'd30, step_win: 8'd6};
    phase_cnt = '0;
    for (int i = 0; i < 3; i++) begin
      sum_acc[i] = 0;
      avg_now[i] = '0;
      avg_prev[i] = '0;
      peak_hi[i] = '0;
      peak_lo[i] = '0;
      weight[i] = '0;
    end
    act_ticks = '0;
    chosen = AXIS_NONE;
    cross_cnt = '0;
    step_ticks = '0;
    steps = '0;
    ticks_due.delete();
  endtask

  // Advance the prediction by one sample; a tick-closing sample yields a result.
  task automatic feed_sample(input gyro_t gx, input gyro_t gy, input gyro_t gz,
                             output bit made, output result_t res);
    gyro_t       smp [3];
    int unsigned delta [3];
    int          avg, was, cur, mid, ch, lo, hi, k;
    axis_t       leader;
    bit          crossed;
    smp[0] = gx;
    smp[1] = gy;
    smp[2] = gz;
    made = 1'b0;
    res = '0;
    crossed = 1'b0;
    for (int i = 0; i < 3; i++) sum_acc[i] += smp[i];
    phase_cnt = phase_cnt + 8'd1;
    if (phase_cnt < TICK_LEN) return;
    phase_cnt = '0;

    // Divide, then keep the new average only when its change lies in the window.
    lo = cfg.min_var;
    hi = cfg.max_var;
    for (int i = 0; i < 3; i++) begin
      avg = sum_acc[i] / TICK_LEN;
      sum_acc[i] = 0;
      avg_prev[i] = avg_now[i];
      was = avg_prev[i];
      ch = avg - was;
      if (ch < 0) ch = -ch;
      if (ch < lo || ch > hi) avg = was;
      avg_now[i] = gyro_t'(avg);
      if (avg > peak_hi[i]) peak_hi[i] = gyro_t'(avg);
      if (avg < peak_lo[i]) peak_lo[i] = gyro_t'(avg);
    end

    // The axis decision uses the weights gathered before this tick.
    act_ticks = act_ticks + 8'd1;
    if (act_ticks >= cfg.act_win) begin
      chosen = pick_leader(weight[0], weight[1], weight[2]);
      act_ticks = '0;
      for (int i = 0; i < 3; i++) weight[i] = '0;
    end

    for (int i = 0; i < 3; i++) begin
      ch = int'(avg_now[i]) - int'(avg_prev[i]);
      delta[i] = (ch < 0) ? -ch : ch;
    end
    leader = pick_leader(delta[0], delta[1], delta[2]);
    if (leader != AXIS_NONE) begin
      k = int'(leader) - 1;
      if (weight[k] != 8'hFF) weight[k] = weight[k] + 8'd1;
    end

    // A strict pass over the midpoint of the chosen axis's peaks.
    if (chosen != AXIS_NONE) begin
      k = int'(chosen) - 1;
      mid = (int'(peak_hi[k]) + int'(peak_lo[k])) / 2;
      was = avg_prev[k];
      cur = avg_now[k];
      if ((was < mid && cur > mid) || (was > mid && cur < mid)) begin
        crossed = 1'b1;
        crossing_total++;
        if (cross_cnt != 16'hFFFF) cross_cnt = cross_cnt + 16'd1;
      end
    end

    step_ticks = step_ticks + 8'd1;
    if (step_ticks >= cfg.step_win) begin
      step_ticks = '0;
      if (cross_cnt != 16'd0) begin
        cross_cnt = '0;
        steps = steps + 32'd1;
      end
    end

    res.step_total = steps;
    res.active_axis = chosen;
    res.crossing_seen = crossed;
    made = 1'b1;
  endtask

  // All channel traffic is sampled at the rising edge.
  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    bit      made;
    if (!rst_n) begin
      clear_state();
      fail_count = 0;
      samples_seen = 0;
      results_seen = 0;
      crossing_total = 0;
    end else begin
      // Register writes land in the copy of the configuration.
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_MIN_VAR:  cfg.min_var = pwdata[15:0];
          REG_MAX_VAR:  cfg.max_var = pwdata[15:0];
          REG_ACT_WIN:  cfg.act_win = pwdata[7:0];
          REG_STEP_WIN: cfg.step_win = pwdata[7:0];
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        samples_seen++;
        feed_sample(in_mon.gyro_x, in_mon.gyro_y, in_mon.gyro_z, made, want);
        if (made) ticks_due.push_back(want);
      end

      if (out_mon.valid && out_mon.ready) begin
        results_seen++;
        got.step_total = out_mon.step_total;
        got.active_axis = out_mon.active_axis;
        got.crossing_seen = out_mon.crossing_seen;
        if (ticks_due.size() == 0) begin
          $error("tick result with none outstanding: step_total %0d, active_axis %0d",
                 got.step_total, got.active_axis);
          fail_count++;
        end else begin
          want = ticks_due.pop_front();
          if (got.step_total !== want.step_total) begin
            $error("step_total: expected %0d, got %0d", want.step_total, got.step_total);
            fail_count++;
          end
          if (got.active_axis !== want.active_axis) begin
            $error("active_axis: expected %0d, got %0d", want.active_axis, got.active_axis);
            fail_count++;
          end
          if (got.crossing_seen !== want.crossing_seen) begin
            $error("crossing_seen: expected %0d, got %0d", want.crossing_seen,
                   got.crossing_seen);
            fail_count++;
          end
        end
      end
    end
    due_count = ticks_due.size();
  end

endmodule

@@ tb/sv/tb_gyro_step_counter.sv @@
`timescale 1ns / 1ps

module tb_gyro_step_counter;
  import gsc_pkg::*;

  localparam int TICK_LEN       = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_TICKS   = 20;
  localparam int N_SETTINGS     = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam gyro_t G_MAX = 16'sh7FFF;
  localparam gyro_t G_MIN = 16'sh8000;

  typedef enum {TICK_SHAPED, TICK_NOISE, TICK_SPIKE} tick_kind_e;
  typedef enum {RX_OPEN, RX_COIN, RX_COMB, RX_HOLD} rx_mode_e;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int fail_count;
  int due_count;
  int samples_seen;
  int results_seen;
  int crossing_total;

  // Sender and receiver pacing.
  int       burst_left = 0;
  int       idle_cycles = 0;
  int       rx_cycle = 0;
  int       rx_stall = 0;
  rx_mode_e rx_mode = RX_OPEN;

  // Shape of the well-formed motion: one leading axis swinging about zero.
  int lead;
  int amp;
  bit swing;
  int drift [3];
  int cur_min = 2;
  int cur_max = 1000;

  cfg_t plan [N_SETTINGS];

  gsc_in_if  in_if ();
  gsc_out_if out_if ();

  gyro_step_counter #(.SAMPLES_PER_TICK(TICK_LEN)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  gsc_tick_checker #(.TICK_LEN(TICK_LEN)) tick_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .fail_count     (fail_count),
    .due_count      (due_count),
    .samples_seen   (samples_seen),
    .results_seen   (results_seen),
    .crossing_total (crossing_total)
  );

  always #2 clk = ~clk;

  // The result side stalls on a pattern that is redrawn at random.
  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 96 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN: begin
        out_if.ready <= 1'b1;
      end
      RX_COIN: begin
        out_if.ready <= $urandom_range(0, 1);
      end
      RX_COMB: begin
        out_if.ready <= (rx_cycle % 7) > 2;
      end
      default: begin
        if (rx_stall != 0) begin
          rx_stall--;
        end else if ($urandom_range(0, 15) == 0) begin
          rx_stall = $urandom_range(5, 20);
        end
        out_if.ready <= (rx_stall == 0);
      end
    endcase
  end

  // The run is stopped when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic gyro_t sat16(input int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return gyro_t'(v);
  endfunction

  // Offer one sample request, opening a new burst with a gap where one is due.
  task automatic send_sample(input gyro_t gx, input gyro_t gy, input gyro_t gz);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(20, 60);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 6);
      end
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.gyro_x <= gx;
    in_if.gyro_y <= gy;
    in_if.gyro_z <= gz;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // One tick's worth of samples about the given per-axis targets.
  task automatic send_tick(input tick_kind_e kind, input int tx, input int ty,
                           input int tz);
    int slot;
    slot = $urandom_range(0, TICK_LEN - 1);
    for (int s = 0; s < TICK_LEN; s++) begin
      if (kind == TICK_NOISE) begin
        send_sample(gyro_t'($urandom), gyro_t'($urandom), gyro_t'($urandom));
      end else if (kind == TICK_SPIKE && s == slot) begin
        send_sample($urandom_range(0, 1) ? G_MAX : G_MIN,
                    $urandom_range(0, 1) ? G_MAX : G_MIN,
                    $urandom_range(0, 1) ? G_MAX : G_MIN);
      end else begin
        send_sample(sat16(tx + int'($urandom_range(0, 6)) - 3),
                    sat16(ty + int'($urandom_range(0, 6)) - 3),
                    sat16(tz + int'($urandom_range(0, 6)) - 3));
      end
    end
  endtask

  // Mostly a swinging leading axis with quieter drifting axes, plus noise and
  // spikes that upset the averages and the peaks.
  task automatic run_random_ticks(input int n);
    int         lo, hi, roll, w;
    int         tgt [3];
    tick_kind_e kind;
    for (int t = 0; t < n; t++) begin
      if (t == 0 || $urandom_range(0, 11) == 0) begin
        lead = $urandom_range(0, 2);
        lo = (cur_min + 1) / 2;
        hi = cur_max / 2;
        if (hi > 12000) hi = 12000;
        if (lo < 1) lo = 1;
        amp = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(1, 12000);
        drift = '{0, 0, 0};
      end
      if ($urandom_range(0, 5) != 0) swing = !swing;
      w = amp / 6 + 1;
      for (int a = 0; a < 3; a++) begin
        if (a == lead) begin
          tgt[a] = swing ? amp : -amp;
        end else begin
          drift[a] += int'($urandom_range(0, 2 * w)) - w;
          if (drift[a] > 2000) drift[a] = 2000;
          if (drift[a] < -2000) drift[a] = -2000;
          tgt[a] = drift[a];
        end
      end
      roll = $urandom_range(0, 99);
      if (roll < 8) kind = TICK_NOISE;
      else if (roll < 12) kind = TICK_SPIKE;
      else kind = TICK_SHAPED;
      send_tick(kind, tgt[0], tgt[1], tgt[2]);
    end
  endtask

  // Hold the sender until every predicted result has come, then let the
  // pipeline settle.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (due_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the port returns to idle before the next request.
  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t s);
    cfg_write(REG_MIN_VAR, 32'(s.min_var));
    cfg_write(REG_MAX_VAR, 32'(s.max_var));
    cfg_write(REG_ACT_WIN, 32'(s.act_win));
    cfg_write(REG_STEP_WIN, 32'(s.step_win));
    cur_min = s.min_var;
    cur_max = s.max_var;
  endtask

  initial begin
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_if.valid <= 1'b0;
    in_if.gyro_x <= '0;
    in_if.gyro_y <= '0;
    in_if.gyro_z <= '0;

    // Full-open and unit windows, then the widest windows, then an inverted
    // variation window with windows far below the running counts, then zero
    // windows, then assorted settings.
    plan[0] = '{min_var: 16'd0, max_var: 16'hFFFF, act_win: 8'd1, step_win: 8'd1};
    plan[1] = '{min_var: 16'd0, max_var: 16'hFFFF, act_win: 8'd255, step_win: 8'd255};
    plan[2] = '{min_var: 16'd3000, max_var: 16'd100, act_win: 8'd4, step_win: 8'd3};
    plan[3] = '{min_var: 16'd1, max_var: 16'd40000, act_win: 8'd0, step_win: 8'd0};
    plan[4] = '{min_var: 16'($urandom_range(0, 50)), max_var: 16'($urandom_range(500, 65535)),
                act_win: 8'($urandom_range(1, 12)), step_win: 8'($urandom_range(1, 8))};
    plan[5] = '{min_var: 16'hFFFF, max_var: 16'hFFFF, act_win: 8'd2, step_win: 8'd2};
    plan[6] = '{min_var: 16'd4, max_var: 16'd2000, act_win: 8'd5, step_win: 8'd4};
    plan[7] = '{min_var: 16'($urandom_range(0, 20)), max_var: 16'($urandom_range(2000, 30000)),
                act_win: 8'($urandom_range(1, 6)), step_win: 8'($urandom_range(1, 5))};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Rails on every axis: both averages far outside the default window.
    repeat (TICK_LEN) send_sample(G_MAX, G_MAX, G_MAX);
    repeat (TICK_LEN) send_sample(G_MIN, G_MIN, G_MIN);
    // x sums to -11, which must truncate to -2 (a change of exactly the minimum);
    // y moves by exactly the maximum, z by one more than it.
    for (int s = 0; s < TICK_LEN; s++) send_sample((s == 3) ? -2 : -3, 1000, 1001);
    // Back again; z alternates bit patterns that average to zero.
    for (int s = 0; s < TICK_LEN; s++) send_sample(0, 0, s[0] ? 16'hAAAA : 16'h5555);
    // Equal changes on all axes, so no axis gains weight; then x leads.
    repeat (TICK_LEN) send_sample(500, 500, 500);
    repeat (TICK_LEN) send_sample(-500, 700, 500);

    run_random_ticks(RANDOM_TICKS);
    for (int p = 0; p < N_SETTINGS; p++) begin
      wait_drained();
      apply_settings(plan[p]);
      run_random_ticks(RANDOM_TICKS);
    end
    wait_drained();

    $display("Covered %0d gyro samples and %0d tick results, %0d of them midpoint crossings,",
             samples_seen, results_seen, crossing_total);
    $display("under %0d register settings from zero and unit windows to full-width ones.",
             N_SETTINGS + 1);
    if (fail_count == 0 && due_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/gsc_pkg.sv
hw/rtl/gsc_if.sv
hw/rtl/gsc_lane.sv
hw/rtl/gsc_merge.sv
hw/rtl/gsc_out_fifo.sv
hw/rtl/gyro_step_counter.sv
hw/rtl/gsc_checker.sv
tb/sv/gsc_tick_checker.sv
tb/sv/tb_gyro_step_counter.sv
